// ===== src/rss_pkg.sv =====
// Shared constants, types and the radius-class table for the radial smoother.
// Used by rss_mac and radial_symmetric_image_smoother.
package rss_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_RADIUS     = 15;
    localparam int RADIUS_CLASSES = 87;
    localparam int BANKS          = 2 * MAX_RADIUS + 1;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int BANK_W         = $clog2(BANKS);
    localparam int LINE_AW        = BANK_W + COL_W;
    localparam int LINE_DEPTH     = BANKS * MAX_WIDTH;
    localparam int CLS_W          = 7;
    localparam int PIX_W          = 24;
    localparam int PROD_W         = 2 * PIX_W;
    localparam int ACC_W          = PROD_W + 10;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [7:0] CLASS_R2 [RADIUS_CLASSES] = '{
        8'd0, 8'd1, 8'd2, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd13, 8'd16, 8'd17, 8'd18,
        8'd20, 8'd25, 8'd26, 8'd29, 8'd32, 8'd34, 8'd36, 8'd37, 8'd40, 8'd41, 8'd45,
        8'd49, 8'd50, 8'd52, 8'd53, 8'd58, 8'd61, 8'd64, 8'd65, 8'd68, 8'd72, 8'd73,
        8'd74, 8'd80, 8'd81, 8'd82, 8'd85, 8'd89, 8'd90, 8'd97, 8'd98, 8'd100,
        8'd101, 8'd104, 8'd106, 8'd109, 8'd113, 8'd116, 8'd117, 8'd121, 8'd122,
        8'd125, 8'd128, 8'd130, 8'd136, 8'd137, 8'd144, 8'd145, 8'd146, 8'd148,
        8'd149, 8'd153, 8'd157, 8'd160, 8'd162, 8'd164, 8'd169, 8'd170, 8'd173,
        8'd178, 8'd180, 8'd181, 8'd185, 8'd193, 8'd194, 8'd196, 8'd197, 8'd200,
        8'd202, 8'd205, 8'd208, 8'd212, 8'd218, 8'd221, 8'd225
    };

    typedef struct packed {
        logic                     en;
        logic [LINE_AW-1:0]       addr;
        logic signed [PIX_W-1:0]  data;
    } line_wr_t;

    typedef struct packed {
        logic                     en;
        logic [CLS_W-1:0]         idx;
        logic signed [PIX_W-1:0]  data;
    } wt_wr_t;

    typedef struct packed {
        logic                     valid;
        logic [LINE_AW-1:0]       addr;
        logic [CLS_W-1:0]         cls;
    } tap_req_t;

    // parallel match against the class table; squared radii outside it give 0
    function automatic logic [CLS_W-1:0] class_of(input logic [7:0] r2);
        logic [CLS_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < RADIUS_CLASSES; i++)
        begin
            if (CLASS_R2[i] == r2)
            begin
                idx = CLS_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/rss_mac.sv =====
// Weight table, banked line store and the multiply-accumulate pipeline.
// Depends on rss_pkg.
module rss_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rss_pkg::line_wr_t                line_wr,
    input  rss_pkg::wt_wr_t                  wt_wr,
    input  rss_pkg::tap_req_t                tap,
    input  logic                             clr,
    output logic signed [rss_pkg::ACC_W-1:0] acc
);
    import rss_pkg::*;

    logic signed [PIX_W-1:0]  line_mem [LINE_DEPTH];
    logic signed [PIX_W-1:0]  wt_mem [RADIUS_CLASSES];

    logic signed [PIX_W-1:0]  pix_q_reg;
    logic signed [PIX_W-1:0]  wt_q_reg;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (line_wr.en)
        begin
            line_mem[line_wr.addr] <= line_wr.data;
        end
        pix_q_reg <= line_mem[tap.addr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_wr.en)
        begin
            wt_mem[wt_wr.idx] <= wt_wr.data;
        end
        wt_q_reg <= wt_mem[tap.cls];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= pix_q_reg * wt_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= tap.valid;
            v2_reg <= v1_reg;
            if (clr)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/radial_symmetric_image_smoother.sv =====
// Top level of the radial image smoother: stream handshake, frame counters,
// tap sequencer and output rounding. Depends on rss_pkg and rss_mac.
//
// Usage: load the 87 class weights (tuser kind 0), then stream pixels (kind 1)
// in raster order followed by flush items (kind 2). Each pixel or flush
// transaction at stream position q stores its sample and, once q reaches
// R*W+R, produces the output pixel for position q-(R*W+R). Transactions that
// produce nothing leave s_tready high. A producing transaction walks the full
// (2R+1)x(2R+1) tap square one tap per cycle through the single read port
// of the line store, then drains the MAC pipeline (ST_DRAIN) and loads the
// output register (ST_DONE). s_tready is low meanwhile.
// The result sits in an output register; the next transaction is taken while
// it waits, and a stalled receiver only holds the finished pixel (a second
// result waits in the sequencer until the register frees up).
// Reset (async, active low) restarts the frame and sets width 4096, height 1,
// radius 3; weights and line store hold no reset value and must be written.
// Any register write restarts the frame; write only while idle.
module radial_symmetric_image_smoother (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [6:0] weight_index, [30:7] value, [31] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] pixel_out
    output logic [0:0]  m_tuser,   // [0] saturated
    output logic        m_tlast,   // last_of_frame
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import rss_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_TAPS, ST_DRAIN, ST_DONE} state_t;

    state_t                   state_reg;
    logic [12:0]              width_reg;
    logic [15:0]              height_reg;
    logic [3:0]               radius_reg;
    logic [16:0]              d_reg;
    logic [27:0]              total_reg;
    logic [28:0]              q_reg;
    logic [LINE_AW-1:0]       in_addr_reg;
    logic [27:0]              p_reg;
    logic [15:0]              orow_reg;
    logic [COL_W-1:0]         ocol_reg;
    logic [LINE_AW-1:0]       paddr_reg;
    logic signed [4:0]        dy_reg;
    logic signed [4:0]        dx_reg;
    logic [1:0]               drain_reg;
    logic                     last_pend_reg;
    logic                     m_tvalid_reg;
    logic [PIX_W-1:0]         pix_out_reg;
    logic                     sat_reg;
    logic                     last_reg;

    logic [12:0]              w_eff;
    logic [15:0]              h_eff;
    logic [3:0]               r_eff;
    logic                     cfg_hit;
    logic                     in_acc;
    logic [1:0]               kind;
    logic [6:0]               widx;
    logic signed [PIX_W-1:0]  value;
    logic                     store_item;
    logic                     emit;

    line_wr_t                 line_wr;
    wt_wr_t                   wt_wr;
    tap_req_t                 tap;
    logic signed [ACC_W-1:0]  acc;

    logic signed [17:0]       rr;
    logic signed [13:0]       cc;
    logic signed [18:0]       row_off;
    logic signed [18:0]       taddr;
    logic [LINE_AW-1:0]       tap_addr;
    logic signed [9:0]        dx_w;
    logic signed [9:0]        dy_w;
    logic [9:0]               r2;
    logic [7:0]               rsq;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  res;
    logic                     res_hi;
    logic                     res_lo;

    assign w_eff = (width_reg == 13'd0) ? 13'd1 :
                   (width_reg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign r_eff = (radius_reg < 4'd3) ? 4'd3 :
                   (radius_reg > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_reg;

    assign cfg_hit = cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT ||
                                cfg_addr == REG_RADIUS);

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign kind       = s_tuser;
    assign widx       = s_tdata[6:0];
    assign value      = s_tdata[30:7];
    assign store_item = in_acc && (kind == KIND_PIXEL || kind == KIND_FLUSH);
    assign emit       = (q_reg >= 29'(d_reg)) && (p_reg < total_reg);

    assign line_wr.en   = store_item;
    assign line_wr.addr = in_addr_reg;
    assign line_wr.data = (kind == KIND_PIXEL) ? value : '0;

    assign wt_wr.en   = in_acc && (kind == KIND_WEIGHT) && (widx < 7'(RADIUS_CLASSES));
    assign wt_wr.idx  = widx;
    assign wt_wr.data = value;

    // line store is circular by stream position: tap = p + dy*W + dx, mod depth
    assign rr      = $signed({2'b00, orow_reg}) + 18'(dy_reg);
    assign cc      = $signed({2'b00, ocol_reg}) + 14'(dx_reg);
    assign row_off = 19'(dy_reg) * $signed({6'b0, w_eff});
    assign taddr   = $signed({2'b00, paddr_reg}) + row_off + 19'(dx_reg);
    assign tap_addr = (taddr < 0) ? LINE_AW'(taddr + 19'(LINE_DEPTH)) :
                      (taddr >= 19'(LINE_DEPTH)) ? LINE_AW'(taddr - 19'(LINE_DEPTH)) :
                      LINE_AW'(taddr);
    assign dx_w = 10'(dx_reg);
    assign dy_w = 10'(dy_reg);
    assign r2   = $unsigned(dx_w * dx_w + dy_w * dy_w);
    assign rsq  = 8'(r_eff) * 8'(r_eff);

    assign tap.valid = (state_reg == ST_TAPS) && (rr >= 0) && (rr < $signed({2'b00, h_eff}))
                       && (cc >= 0) && (cc < $signed({1'b0, w_eff})) && (r2 <= 10'(rsq));
    assign tap.addr  = tap_addr;
    assign tap.cls   = class_of(r2[7:0]);

    rss_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .line_wr (line_wr),
        .wt_wr   (wt_wr),
        .tap     (tap),
        .clr     (in_acc),
        .acc     (acc)
    );

    // round half up, then floor shift by 23
    assign rounded = acc + (ACC_W'(1) <<< 22);
    assign res     = rounded >>> 23;
    assign res_hi  = res > ACC_W'(8388607);
    assign res_lo  = res < -ACC_W'(8388608);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 13'd4096;
            height_reg    <= 16'd1;
            radius_reg    <= 4'd3;
            d_reg         <= 17'd12291;
            total_reg     <= 28'd4096;
            q_reg         <= '0;
            in_addr_reg   <= '0;
            p_reg         <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            paddr_reg     <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            drain_reg     <= '0;
            last_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            pix_out_reg   <= '0;
            sat_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            d_reg     <= 17'(r_eff) * 17'(w_eff) + 17'(r_eff);
            total_reg <= 28'(w_eff) * 28'(h_eff);

            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                case (cfg_addr)
                    REG_WIDTH:  width_reg  <= cfg_data[12:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[3:0];
                    default:    width_reg  <= width_reg;
                endcase
                q_reg       <= '0;
                in_addr_reg <= '0;
                p_reg       <= '0;
                orow_reg    <= '0;
                ocol_reg    <= '0;
                paddr_reg   <= '0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (store_item)
                    begin
                        q_reg       <= q_reg + 29'd1;
                        in_addr_reg <= (in_addr_reg == LINE_AW'(LINE_DEPTH - 1)) ? '0 :
                                       in_addr_reg + 1'b1;
                        if (emit)
                        begin
                            state_reg     <= ST_TAPS;
                            dy_reg        <= -$signed({1'b0, r_eff});
                            dx_reg        <= -$signed({1'b0, r_eff});
                            last_pend_reg <= (p_reg == total_reg - 28'd1);
                        end
                    end
                end
                ST_TAPS:
                begin
                    if (dx_reg == $signed({1'b0, r_eff}))
                    begin
                        dx_reg <= -$signed({1'b0, r_eff});
                        dy_reg <= dy_reg + 5'sd1;
                        if (dy_reg == $signed({1'b0, r_eff}))
                        begin
                            state_reg <= ST_DRAIN;
                            drain_reg <= '0;
                        end
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 5'sd1;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd2)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        pix_out_reg  <= res_hi ? 24'h7FFFFF :
                                        res_lo ? 24'h800000 : res[PIX_W-1:0];
                        sat_reg      <= res_hi || res_lo;
                        last_reg     <= last_pend_reg;
                        state_reg    <= ST_IDLE;
                        if (last_pend_reg)
                        begin
                            q_reg       <= '0;
                            in_addr_reg <= '0;
                            p_reg       <= '0;
                            orow_reg    <= '0;
                            ocol_reg    <= '0;
                            paddr_reg   <= '0;
                        end
                        else
                        begin
                            p_reg     <= p_reg + 28'd1;
                            paddr_reg <= (paddr_reg == LINE_AW'(LINE_DEPTH - 1)) ? '0 :
                                         paddr_reg + 1'b1;
                            if (13'(ocol_reg) + 13'd1 >= w_eff)
                            begin
                                ocol_reg <= '0;
                                orow_reg <= orow_reg + 16'd1;
                            end
                            else
                            begin
                                ocol_reg <= ocol_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pix_out_reg;
    assign m_tuser  = sat_reg;
    assign m_tlast  = last_reg;

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAPS) |-> (p_reg < total_reg))
        else $error("output position beyond frame while computing");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (13'(ocol_reg) < w_eff))
        else $error("column counter beyond row width");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_addr_reg < LINE_AW'(LINE_DEPTH)) && (paddr_reg < LINE_AW'(LINE_DEPTH)))
        else $error("line store address out of range");

endmodule
